>>> design/bnc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bnc_pkg;

  localparam int BNC_STACK_DEPTH = 32;

  localparam int SYM_W    = 8;
  localparam int CODE_W   = 3;
  localparam int CSCORE_W = 15;
  localparam int COMP_W   = 64;
  localparam int TOTAL_W  = 32;
  localparam int STATUS_W = 2;

  localparam int Q_DEPTH  = 2;

  // ascii brackets
  localparam logic [SYM_W-1:0] CH_OPEN_PAREN  = 8'h28;
  localparam logic [SYM_W-1:0] CH_OPEN_SQUARE = 8'h5B;
  localparam logic [SYM_W-1:0] CH_OPEN_CURLY  = 8'h7B;
  localparam logic [SYM_W-1:0] CH_OPEN_ANGLE  = 8'h3C;
  localparam logic [SYM_W-1:0] CH_CLOSE_PAREN  = 8'h29;
  localparam logic [SYM_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [SYM_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [SYM_W-1:0] CH_CLOSE_ANGLE  = 8'h3E;

  // bracket kind codes, shared by openers and closers
  localparam logic [CODE_W-1:0] CODE_NONE   = 3'd0;
  localparam logic [CODE_W-1:0] CODE_PAREN  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_SQUARE = 3'd2;
  localparam logic [CODE_W-1:0] CODE_CURLY  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_ANGLE  = 3'd4;

  localparam logic [CSCORE_W-1:0] SCORE_PAREN  = 15'd3;
  localparam logic [CSCORE_W-1:0] SCORE_SQUARE = 15'd57;
  localparam logic [CSCORE_W-1:0] SCORE_CURLY  = 15'd1197;
  localparam logic [CSCORE_W-1:0] SCORE_ANGLE  = 15'd25137;

  typedef enum logic [STATUS_W-1:0] {
    ST_BALANCED   = 2'd0,
    ST_CORRUPT    = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_OVERFLOW   = 2'd3
  } line_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CRD,
    S_CACC,
    S_EMIT
  } back_state_t;

  typedef struct packed {
    logic              closer;
    logic [CODE_W-1:0] code;
    logic              eol;
  } bnc_op_t;

  function automatic logic [CODE_W-1:0] opener_code(input logic [SYM_W-1:0] sym);
    logic [CODE_W-1:0] c;
    case (sym)
      CH_OPEN_PAREN:  c = CODE_PAREN;
      CH_OPEN_SQUARE: c = CODE_SQUARE;
      CH_OPEN_CURLY:  c = CODE_CURLY;
      CH_OPEN_ANGLE:  c = CODE_ANGLE;
      default:        c = CODE_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [CODE_W-1:0] closer_need(input logic [SYM_W-1:0] sym);
    logic [CODE_W-1:0] c;
    case (sym)
      CH_CLOSE_PAREN:  c = CODE_PAREN;
      CH_CLOSE_SQUARE: c = CODE_SQUARE;
      CH_CLOSE_CURLY:  c = CODE_CURLY;
      CH_CLOSE_ANGLE:  c = CODE_ANGLE;
      default:         c = CODE_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [CSCORE_W-1:0] closer_score(input logic [CODE_W-1:0] need);
    logic [CSCORE_W-1:0] s;
    case (need)
      CODE_PAREN:  s = SCORE_PAREN;
      CODE_SQUARE: s = SCORE_SQUARE;
      CODE_CURLY:  s = SCORE_CURLY;
      default:     s = SCORE_ANGLE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> design/bnc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bnc_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/bnc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bnc_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [bnc_pkg::SYM_W-1:0]  in_symbol,
  input  wire logic                       in_end_of_line,
  input  wire logic                       push,
  output logic                            full,
  output logic                            q_valid,
  output bnc_pkg::bnc_op_t                q_op,
  input  wire logic                       q_pop
);

  import bnc_pkg::*;

  localparam int CW = $clog2(Q_DEPTH + 1);
  localparam int PW = $clog2(Q_DEPTH);

  bnc_op_t         q_r [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            acc;
  logic            deq;
  bnc_op_t         op_in;
  logic [CODE_W-1:0] need;

  // classify the incoming character
  always_comb begin
    need         = closer_need(in_symbol);
    op_in.closer = (need != CODE_NONE);
    op_in.code   = (need != CODE_NONE) ? need : opener_code(in_symbol);
    op_in.eol    = in_end_of_line;
  end

  assign full    = (cnt_r == CW'(Q_DEPTH));
  assign acc     = push && !full;
  assign q_valid = (cnt_r != '0);
  assign deq     = q_pop && q_valid;
  assign q_op    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = acc ? ((wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1)) : wr_ptr_r;
    rd_ptr_nxt = deq ? ((rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1)) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(acc) - CW'(deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

`default_nettype wire

>>> design/bnc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bnc_back #(
  parameter int STACK_DEPTH = bnc_pkg::BNC_STACK_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire bnc_pkg::bnc_op_t             q_op,
  output logic                              q_pop,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [bnc_pkg::STATUS_W-1:0]      out_line_status,
  output logic [bnc_pkg::CSCORE_W-1:0]      out_corruption_score,
  output logic [bnc_pkg::COMP_W-1:0]        out_completion_score,
  output logic [bnc_pkg::TOTAL_W-1:0]       out_running_total
);

  import bnc_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  back_state_t           state_r, state_nxt;
  bnc_op_t               op_r, op_nxt;
  logic [LW-1:0]         level_r, level_nxt;
  logic                  corrupt_r, corrupt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [CSCORE_W-1:0]   err_r, err_nxt;
  logic [TOTAL_W-1:0]    total_r, total_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [COMP_W-1:0]     comp_r, comp_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [LW-1:0]         level_dec;
  logic [LW-1:0]         level_nxt_dec;
  logic [TOTAL_W:0]      total_sum;
  logic [CSCORE_W-1:0]   score;
  logic                  out_free;
  logic                  out_load;
  line_status_t          status;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic                  re;
  logic [AW-1:0]         raddr;
  logic [CODE_W-1:0]     rdata;

  bnc_ram #(
    .WIDTH (CODE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (op_r.code),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free = !out_valid_r || pop;
  assign empty    = !out_valid_r;

  always_comb begin
    if (ovf_r) begin
      status = ST_OVERFLOW;
    end else if (corrupt_r) begin
      status = ST_CORRUPT;
    end else if (level_r == '0) begin
      status = ST_BALANCED;
    end else begin
      status = ST_INCOMPLETE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    level_nxt     = level_r;
    corrupt_nxt   = corrupt_r;
    ovf_nxt       = ovf_r;
    err_nxt       = err_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    comp_nxt      = comp_r;
    out_load      = 1'b0;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = level_r[AW-1:0];
    re            = 1'b0;
    level_dec     = level_r - LW'(1);
    raddr         = level_dec[AW-1:0];
    score         = closer_score(op_r.code);
    total_sum     = {1'b0, total_r} + (TOTAL_W+1)'(score);
    level_nxt_dec = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          op_nxt    = q_op;
          re        = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!corrupt_r && !ovf_r) begin
          if (op_r.closer) begin
            if (level_r != '0 && rdata == op_r.code) begin
              level_nxt = level_dec;
            end else begin
              corrupt_nxt = 1'b1;
              err_nxt     = score;
              total_nxt   = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            end
          end else if (level_r == LW'(STACK_DEPTH)) begin
            ovf_nxt = 1'b1;
          end else begin
            we        = 1'b1;
            level_nxt = level_r + LW'(1);
          end
        end
        level_nxt_dec = level_nxt - LW'(1);
        if (!op_r.eol) begin
          state_nxt = S_IDLE;
        end else begin
          comp_nxt = '0;
          idx_nxt  = level_nxt_dec[AW-1:0];
          if (corrupt_nxt || ovf_nxt || level_nxt == '0) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_CRD;
          end
        end
      end
      S_CRD: begin
        re        = 1'b1;
        raddr     = idx_r;
        state_nxt = S_CACC;
      end
      S_CACC: begin
        // top first: score = score * 5 + code
        comp_nxt = {comp_r[COMP_W-3:0], 2'b00} + comp_r + COMP_W'(rdata);
        if (idx_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = idx_r - AW'(1);
          state_nxt = S_CRD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          level_nxt   = '0;
          corrupt_nxt = 1'b0;
          ovf_nxt     = 1'b0;
          err_nxt     = '0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      corrupt_r   <= 1'b0;
      ovf_r       <= 1'b0;
      err_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      corrupt_r   <= corrupt_nxt;
      ovf_r       <= ovf_nxt;
      err_r       <= err_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    idx_r  <= idx_nxt;
    comp_r <= comp_nxt;
    if (out_load) begin
      out_line_status      <= status;
      out_corruption_score <= (status == ST_CORRUPT) ? err_r : '0;
      out_completion_score <= (status == ST_INCOMPLETE) ? comp_r : '0;
      out_running_total    <= total_r;
    end
  end

endmodule

`default_nettype wire

>>> design/bracket_nesting_checker.sv
// bracket nesting checker
// input channel: in_symbol/in_end_of_line, written with push while full is low;
// one beat is one character, in_end_of_line marks the last character of a line
// result channel: a result beat per line, read with pop while empty is low;
// it carries the line status, the score of the first illegal closer, the
// base-5 completion score of the openers left open and the running total
// characters pass through a two-entry queue into the stack engine; there each
// character is a stack memory read, then a push or pop, and the engine takes
// the next character only once it is through with the last one
// after the last character of a line the engine goes on to emit the result;
// for an incomplete line it first reads each opener still open from the
// single read port of the stack memory and scores it in turn
// synchronous reset clears the queue, the stack level, the line flags, the
// running total and result valid; stack memory and result data are not cleared
// when pop stays low the result is held and the engine waits with the next
// result; the queue keeps accepting characters until it fills, then full rises
`timescale 1ns / 1ps
`default_nettype none

module bracket_nesting_checker #(
  parameter int STACK_DEPTH = bnc_pkg::BNC_STACK_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [bnc_pkg::SYM_W-1:0]    in_symbol,
  input  wire logic                         in_end_of_line,
  input  wire logic                         push,
  output logic                              full,
  output logic [bnc_pkg::STATUS_W-1:0]      out_line_status,
  output logic [bnc_pkg::CSCORE_W-1:0]      out_corruption_score,
  output logic [bnc_pkg::COMP_W-1:0]        out_completion_score,
  output logic [bnc_pkg::TOTAL_W-1:0]       out_running_total,
  output logic                              empty,
  input  wire logic                         pop
);

  import bnc_pkg::*;

  logic    q_valid;
  logic    q_pop;
  bnc_op_t q_op;

  bnc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_symbol      (in_symbol),
    .in_end_of_line (in_end_of_line),
    .push           (push),
    .full           (full),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .q_pop          (q_pop)
  );

  bnc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_op                 (q_op),
    .q_pop                (q_pop),
    .empty                (empty),
    .pop                  (pop),
    .out_line_status      (out_line_status),
    .out_corruption_score (out_corruption_score),
    .out_completion_score (out_completion_score),
    .out_running_total    (out_running_total)
  );

endmodule

`default_nettype wire
